@@ rtl/storage_io_request_generator_macros.svh @@
// Assertion macros shared by the storage I/O request generator RTL.
`ifndef STORAGE_IO_REQUEST_GENERATOR_MACROS_SVH
`define STORAGE_IO_REQUEST_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SIRG_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIRG_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sirg_pkg.sv @@
// Package: widths, register indexes and shared types of the request generator.
package sirg_pkg;

	localparam int unsigned BLK_W    = 25;   // block count width
	localparam int unsigned BBYTES_W = 21;
	localparam int unsigned PCT_W    = 7;
	localparam int unsigned OPM_W    = 2;
	localparam int unsigned IDX_W    = 24;
	localparam int unsigned WORD_W   = 64;
	localparam int unsigned OFS_W    = 44;
	localparam int unsigned THR_W    = 32;   // blocks * percent
	localparam int unsigned REGI_W   = 3;

	localparam logic [32:0] MAX_BLOCKS_DEF = 33'd16777216;

	localparam logic [BLK_W-1:0]    BLK_COUNT_RST   = BLK_W'(16384);
	localparam logic [BBYTES_W-1:0] BLOCK_BYTES_RST = BBYTES_W'(4096);
	localparam logic [PCT_W-1:0]    MIX_PCT_RST     = PCT_W'(70);

	localparam logic [REGI_W-1:0] REG_BLK_COUNT   = 3'd0;
	localparam logic [REGI_W-1:0] REG_BLOCK_BYTES = 3'd1;
	localparam logic [REGI_W-1:0] REG_RANDOM_MODE = 3'd2;
	localparam logic [REGI_W-1:0] REG_OP_MODE     = 3'd3;
	localparam logic [REGI_W-1:0] REG_MIX_PCT     = 3'd4;
	localparam logic [REGI_W-1:0] REG_SEED        = 3'd5;

	localparam logic [OPM_W-1:0] OP_READ  = 2'd0;
	localparam logic [OPM_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OPM_W-1:0] OP_MIX   = 2'd2;

	localparam logic [THR_W:0] PCT_SCALE = 33'd100;

	// xorshift64 shifts
	localparam int unsigned XS_A = 13;
	localparam int unsigned XS_B = 7;
	localparam int unsigned XS_C = 17;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [WORD_W-1:0] xorshift_next(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] x;
		x = s;
		x = x ^ (x << XS_A);
		x = x ^ (x >> XS_B);
		x = x ^ (x << XS_C);
		return x;
	endfunction

endpackage

@@ rtl/storage_io_request_generator.sv @@
// Top level: storage I/O request generator (offset and direction per request index).
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_stall  | request_index
//  out     | out_valid / out_stall| byte_offset, is_write
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request runs the shared restoring divider once for its block remainder and, in
// mixed mode, once more for the permuted value, with sequencer states around each run.
// in_stall is high from acceptance until the result is loaded into the output
// register; a stalled full output register holds the sequencer in its last state.
// Reset restores register defaults and a generator state of 1. cfg_ready is
// always high; writes are expected only while idle.
`include "storage_io_request_generator_macros.svh"

module storage_io_request_generator import sirg_pkg::*; #(
	parameter logic [32:0] MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [IDX_W-1:0]  request_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [OFS_W-1:0]  byte_offset,
	output logic              is_write,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [REGI_W-1:0] cfg_index,
	input  logic [WORD_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RBLK,
		ST_MUL,
		ST_PERM,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [BLK_W-1:0]    blk_count_q;
	logic [BBYTES_W-1:0] block_bytes_q;
	logic                random_mode_q;
	logic [OPM_W-1:0]    op_mode_q;
	logic [PCT_W-1:0]    mix_pct_q;
	logic [WORD_W-1:0]   seed_q;
	logic [WORD_W-1:0]   prng_q;

	logic [IDX_W-1:0]    idx_q;
	logic [BLK_W-1:0]    blocks_q;
	logic [BLK_W-1:0]    block_q;
	logic [BLK_W-1:0]    perm_q;
	logic [OFS_W-1:0]    ofs_q;
	logic [THR_W-1:0]    thr_q;
	logic                wr_q;
	logic [OFS_W-1:0]    out_ofs_q;
	logic                out_wr_q;
	logic                out_valid_q;

	logic                in_acc;
	logic                out_free;
	logic                cfg_acc;
	logic [BLK_W-1:0]    eff_blocks;
	logic [WORD_W-1:0]   prng_next;
	logic [WORD_W-1:0]   mix_sum;
	logic [BLK_W+BBYTES_W-1:0] prod;
	logic [THR_W:0]      perm_scaled;

	div_ctl_t            div_ctl;
	div_stat_t           div_stat;
	logic [WORD_W-1:0]   div_dividend;
	logic [BLK_W-1:0]    div_rem;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// zero acts as one block, oversize counts clamp to MAX_BLOCKS
	always_comb begin
		if (blk_count_q == '0) begin
			eff_blocks = BLK_W'(1);
		end else if ({8'd0, blk_count_q} > MAX_BLOCKS) begin
			eff_blocks = MAX_BLOCKS[BLK_W-1:0];
		end else begin
			eff_blocks = blk_count_q;
		end
	end

	assign prng_next = xorshift_next(prng_q);
	// index * 65537 + seed, wrapping at 64 bits
	assign mix_sum   = WORD_W'(idx_q) + (WORD_W'(idx_q) << 16) + seed_q;
	assign prod      = (BLK_W+BBYTES_W)'(block_q) * (BLK_W+BBYTES_W)'(block_bytes_q);
	// permuted >= floor(thr/100)  <=>  100 * (permuted + 1) > thr
	assign perm_scaled = (THR_W+1)'(perm_q) * PCT_SCALE + PCT_SCALE;

	assign div_ctl.start = in_acc || (state_q == ST_MUL && op_mode_q == OP_MIX);
	assign div_dividend  = (state_q == ST_IDLE)
		? (random_mode_q ? prng_next : WORD_W'(request_index))
		: mix_sum;

	sirg_divu u_divu (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_dividend),
		.divisor   ((state_q == ST_IDLE) ? eff_blocks : blocks_q),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	// configuration registers and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_count_q    <= BLK_COUNT_RST;
			block_bytes_q  <= BLOCK_BYTES_RST;
			random_mode_q  <= 1'b0;
			op_mode_q      <= OP_READ;
			mix_pct_q      <= MIX_PCT_RST;
			seed_q         <= '0;
			prng_q         <= WORD_W'(1);
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_BLK_COUNT:    blk_count_q    <= cfg_data[BLK_W-1:0];
					REG_BLOCK_BYTES:  block_bytes_q  <= cfg_data[BBYTES_W-1:0];
					REG_RANDOM_MODE:  random_mode_q  <= cfg_data[0];
					REG_OP_MODE:      op_mode_q      <= cfg_data[OPM_W-1:0];
					REG_MIX_PCT:      mix_pct_q      <= cfg_data[PCT_W-1:0];
					REG_SEED: begin
						seed_q <= cfg_data;
						prng_q <= (cfg_data == '0) ? WORD_W'(1) : cfg_data;
					end
					default: ;
				endcase
			end else if (in_acc && random_mode_q) begin
				prng_q <= prng_next;
			end
		end
	end

	// sequencer with output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			blocks_q    <= '0;
			block_q     <= '0;
			perm_q      <= '0;
			ofs_q       <= '0;
			thr_q       <= '0;
			wr_q        <= 1'b0;
			out_ofs_q   <= '0;
			out_wr_q    <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q    <= request_index;
						blocks_q <= eff_blocks;
						state_q  <= ST_RBLK;
					end
				end
				ST_RBLK: begin
					if (div_stat.done) begin
						block_q <= div_rem;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					ofs_q <= prod[OFS_W-1:0];
					thr_q <= THR_W'(blocks_q) * THR_W'(mix_pct_q);
					wr_q  <= (op_mode_q == OP_WRITE);
					state_q <= (op_mode_q == OP_MIX) ? ST_PERM : ST_DONE;
				end
				ST_PERM: begin
					if (div_stat.done) begin
						perm_q  <= div_rem;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					wr_q    <= perm_scaled > {1'b0, thr_q};
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_ofs_q   <= ofs_q;
						out_wr_q    <= wr_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign byte_offset = out_ofs_q;
	assign is_write    = out_wr_q;

	`SIRG_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, in_stall,
		"request accepted but input not stalled next cycle")
	`SIRG_ASSERT_NOW(a_div_start_idle, clk, arst_n, div_ctl.start, !div_stat.busy,
		"divider started while busy")
	`SIRG_ASSERT_NOW(a_div_done_state, clk, arst_n, div_stat.done,
		state_q == ST_RBLK || state_q == ST_PERM,
		"divider finished outside a wait state")
	`SIRG_ASSERT_NOW(a_block_in_range, clk, arst_n, state_q == ST_MUL, block_q < blocks_q,
		"block number not below block count")

endmodule

@@ rtl/sirg_divu.sv @@
// Restoring remainder unit: 64-bit dividend mod 25-bit divisor, one bit per cycle.
module sirg_divu import sirg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_ctl_t          ctl,
	input  logic [WORD_W-1:0] dividend,
	input  logic [BLK_W-1:0]  divisor,
	output div_stat_t         stat,
	output logic [BLK_W-1:0]  remainder
);

	localparam int unsigned CNT_W = $clog2(WORD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

	logic [WORD_W-1:0] num_q;
	logic [BLK_W-1:0]  den_q;
	logic [BLK_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [BLK_W:0]    trial;
	logic [BLK_W:0]    diff;
	logic              fits;

	// remainder stays below the divisor, so the difference always fits BLK_W bits
	assign trial = {rem_q, num_q[WORD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[BLK_W-1:0] : trial[BLK_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule
